[src/sts_pkg.sv]
// Shared types, sizes and codes for the sum tree weighted sampler.
package sts_pkg;

   localparam int LEAVES        = 64;
   localparam int WEIGHT_BITS   = 16;
   localparam int FRACTION_BITS = 16;
   localparam int INDEX_BITS    = 6;
   localparam int OP_BITS       = 2;

   // Default tree geometry for LEAVES
   localparam int LEVELS    = $clog2(LEAVES);
   localparam int ADDR_BITS = LEVELS + 1;
   localparam int SUM_BITS  = WEIGHT_BITS - 1 + LEVELS;

   typedef enum logic [OP_BITS-1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_DRAW  = 2'd2
   } op_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      op_type                         operation;
      logic signed [WEIGHT_BITS-1:0]  weight;
      logic [FRACTION_BITS-1:0]       random_fraction;
   } req_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] chosen_index;
      logic                  empty_res;
   } rsp_type;

endpackage

[src/sum_tree_weighted_sampler.sv]
// Weighted random sampler over a binary sum tree held in a node memory.
//
// Input channel req_*: one item per handshake (valid high, stall low).
//   clear: empties the tree, no result.
//   load:  stores the next weight (negative counts as zero) and rebuilds its
//          path; no result. Ignored when full.
//   draw:  picks a leaf with probability proportional to its weight, then
//          zeroes it. It runs the total read, scale multiply, descent, rebuild
//          and response states in order (an empty tree goes straight to the
//          response); the next item is taken once the result is registered.
// Each tree level is visited once going down and once going up: the node
// memory gives one read and one write per cycle, and one adder does both the
// compare-subtract and the rebuild. The scale multiply has its own state.
// Result channel rsp_*: one item per draw, index 0 with empty_res set when
// the total weight is zero. A stalled result holds; a draw that finishes
// while an older result is still stalled waits before the output register.
// Reset (synchronous) empties the tree at once: node entries whose subtree
// has no loaded leaf read as zero, so no clearing pass is needed.
module sum_tree_weighted_sampler #(
   parameter int LEAVES = sts_pkg::LEAVES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sts_pkg::rsp_type rsp_data
);

   localparam int LEVELS = $clog2(LEAVES);
   localparam int AW     = LEVELS + 1;
   localparam int SW     = sts_pkg::WEIGHT_BITS - 1 + LEVELS;
   localparam int CW     = $clog2(LEAVES + 1);
   localparam int FB     = sts_pkg::FRACTION_BITS;
   localparam int WB     = sts_pkg::WEIGHT_BITS;
   localparam logic [LEVELS-1:0] SPAN_TOP = LEVELS'(1) << (LEVELS - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_TOT,
      S_MUL,
      S_DN,
      S_UP,
      S_RSP
   } state_type;

   state_type        state_ff, state_in;
   logic             is_draw_ff, is_draw_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [AW-1:0]    addr_ff, addr_in;
   logic [LEVELS-1:0] lo_ff, lo_in;
   logic [LEVELS-1:0] span_ff, span_in;
   logic [SW-1:0]    val_ff, val_in;
   logic [SW-1:0]    target_ff, target_in;
   logic [SW-1:0]    total_ff, total_in;
   logic [FB-1:0]    frac_ff, frac_in;
   logic             empty_ff, empty_in;
   logic             rsp_valid_ff, rsp_valid_in;
   sts_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [SW-1:0]    wr_data;
   logic [AW-1:0]    rd_addr;
   logic [SW-1:0]    rd_data;

   sts_pkg::alu_op_type alu_op;
   logic [SW-1:0]    alu_a;
   logic [SW-1:0]    alu_res;
   logic             alu_borrow;

   logic [SW-1:0]    w_clamped;
   logic [AW-1:0]    leaf_addr;
   logic [LEVELS-1:0] sib_lo;
   logic [LEVELS-1:0] chk_lo;
   logic             node_valid;
   logic [SW-1:0]    node_q;
   logic [SW-1:0]    root_q;
   logic [SW+FB-1:0] product;
   logic [AW-1:0]    child;
   logic [AW-1:0]    parent;

   sts_ram #(
      .ADDR_BITS (AW),
      .DATA_BITS (SW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sts_alu #(
      .SUM_BITS (SW)
   ) u_alu (
      .op     (alu_op),
      .a      (alu_a),
      .b      (node_q),
      .res    (alu_res),
      .borrow (alu_borrow)
   );

   assign w_clamped = req_data.weight[WB-1] ? '0 : SW'(req_data.weight[WB-2:0]);
   assign leaf_addr = {1'b1, count_ff[LEVELS-1:0]};

   // A node holds live data only if its leftmost leaf has been loaded since clear
   assign sib_lo     = (lo_ff & ~LEVELS'(span_ff - LEVELS'(1))) ^ span_ff;
   assign chk_lo     = (state_ff == S_DN) ? lo_ff : sib_lo;
   assign node_valid = CW'(chk_lo) < count_ff;
   assign node_q     = node_valid ? rd_data : '0;
   assign root_q     = (count_ff != '0) ? rd_data : '0;

   assign alu_op = (state_ff == S_DN) ? sts_pkg::ALU_SUB : sts_pkg::ALU_ADD;
   assign alu_a  = (state_ff == S_DN) ? target_ff : val_ff;

   assign product = total_ff * frac_ff;
   assign child   = {addr_ff[AW-2:0], ~alu_borrow};
   assign parent  = AW'(addr_ff[AW-1:1]);

   always_comb begin
      state_in     = state_ff;
      is_draw_in   = is_draw_ff;
      count_in     = count_ff;
      addr_in      = addr_ff;
      lo_in        = lo_ff;
      span_in      = span_ff;
      val_in       = val_ff;
      target_in    = target_ff;
      total_in     = total_ff;
      frac_in      = frac_ff;
      empty_in     = empty_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = '0;
      rd_addr      = addr_ff ^ AW'(1);

      unique case (state_ff)
         S_IDLE: begin
            rd_addr = AW'(1);
            if (req_valid) begin
               unique case (req_data.operation)
                  sts_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  sts_pkg::OP_LOAD: begin
                     if (count_ff < CW'(LEAVES)) begin
                        wr_en      = 1'b1;
                        wr_addr    = leaf_addr;
                        wr_data    = w_clamped;
                        rd_addr    = leaf_addr ^ AW'(1);
                        addr_in    = leaf_addr;
                        lo_in      = count_ff[LEVELS-1:0];
                        span_in    = LEVELS'(1);
                        val_in     = w_clamped;
                        count_in   = count_ff + CW'(1);
                        is_draw_in = 1'b0;
                        state_in   = S_UP;
                     end
                  end
                  sts_pkg::OP_DRAW: begin
                     frac_in    = req_data.random_fraction;
                     is_draw_in = 1'b1;
                     state_in   = S_TOT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_TOT: begin
            if (root_q == '0) begin
               empty_in = 1'b1;
               lo_in    = '0;
               state_in = S_RSP;
            end else begin
               empty_in = 1'b0;
               total_in = root_q;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            target_in = product[SW+FB-1:FB];
            addr_in   = AW'(1);
            lo_in     = '0;
            span_in   = SPAN_TOP;
            rd_addr   = AW'(2);
            state_in  = S_DN;
         end
         S_DN: begin
            addr_in = child;
            span_in = span_ff >> 1;
            if (!alu_borrow) begin
               target_in = alu_res;
               lo_in     = lo_ff | span_ff;
            end
            if (span_ff == LEVELS'(1)) begin
               // reached a leaf: zero it and start the rebuild
               wr_en    = 1'b1;
               wr_addr  = child;
               wr_data  = '0;
               rd_addr  = child ^ AW'(1);
               val_in   = '0;
               span_in  = LEVELS'(1);
               state_in = S_UP;
            end else begin
               rd_addr = {child[AW-2:0], 1'b0};
            end
         end
         S_UP: begin
            wr_en   = 1'b1;
            wr_addr = parent;
            wr_data = alu_res;
            val_in  = alu_res;
            addr_in = parent;
            span_in = span_ff << 1;
            rd_addr = parent ^ AW'(1);
            if (parent == AW'(1)) begin
               state_in = is_draw_ff ? S_RSP : S_IDLE;
            end
         end
         S_RSP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.chosen_index = sts_pkg::INDEX_BITS'(lo_ff);
               rsp_data_in.empty_res    = empty_ff;
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      is_draw_ff  <= is_draw_in;
      addr_ff     <= addr_in;
      lo_ff       <= lo_in;
      span_ff     <= span_in;
      val_ff      <= val_in;
      target_ff   <= target_in;
      total_ff    <= total_in;
      frac_ff     <= frac_in;
      empty_ff    <= empty_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_load_counts: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.operation == sts_pkg::OP_LOAD
      && count_ff < CW'(LEAVES) |=> count_ff == $past(count_ff) + CW'(1))
      else $error("load did not advance the loaded count");

   a_target_below_total: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DN |-> target_ff < total_ff)
      else $error("descent target not below root total");

   a_no_slot_zero: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> wr_addr != '0)
      else $error("write to unused node slot");

   a_result_from_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_RSP)
      else $error("result raised outside the response state");
`endif

endmodule

[src/sts_ram.sv]
// Node sum memory: one write port, one read port with registered data.
module sts_ram #(
   parameter int ADDR_BITS = sts_pkg::ADDR_BITS,
   parameter int DATA_BITS = sts_pkg::SUM_BITS
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem_ff [0:(1 << ADDR_BITS)-1];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/sts_alu.sv]
// Shared adder/subtractor used for both the descent and the path rebuild.
module sts_alu #(
   parameter int SUM_BITS = sts_pkg::SUM_BITS
) (
   input  sts_pkg::alu_op_type  op,
   input  logic [SUM_BITS-1:0]  a,
   input  logic [SUM_BITS-1:0]  b,
   output logic [SUM_BITS-1:0]  res,
   output logic                 borrow
);

   logic [SUM_BITS:0] wide;

   always_comb begin
      case (op)
         sts_pkg::ALU_ADD: wide = {1'b0, a} + {1'b0, b};
         sts_pkg::ALU_SUB: wide = {1'b0, a} - {1'b0, b};
         default:          wide = '0;
      endcase
   end

   assign res    = wide[SUM_BITS-1:0];
   assign borrow = (op == sts_pkg::ALU_SUB) && wide[SUM_BITS];

endmodule

[tb/sum_tree_weighted_sampler_tb.sv]
// Testbench for sum_tree_weighted_sampler: tree sum predictor with randomized load/draw traffic.
`timescale 1ns / 100ps

module sum_tree_weighted_sampler_tb;
   import sts_pkg::*;

   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 40;
   localparam int CYCLE_LIMIT     = 500000;
   localparam int RANDOM_ITEMS    = 1150;
   localparam int TOTAL_ITEMS     = 1300;

   typedef enum int {
      WEIGHTS_ANY,
      WEIGHTS_POSITIVE,
      WEIGHTS_TINY,
      WEIGHTS_EDGE
   } weight_style_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // predictor state
   logic [SUM_BITS-1:0] tree_sums [0:2*LEAVES-2];
   int                  weights_loaded;
   rsp_type             expected_draws[$];

   int error_count;
   int accepted_count;
   int cycle_count;
   bit quiet_phase;
   bit hold_off_request;

   sum_tree_weighted_sampler i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void rebuild_tree_path(int leaf);
      int node;
      node = leaf;
      while (node > 0) begin
         node = (node - 1) / 2;
         tree_sums[node] = tree_sums[2*node+1] + tree_sums[2*node+2];
      end
   endfunction

   function automatic void predict_item(req_type item);
      int                  node;
      logic [SUM_BITS-1:0] target;
      logic [63:0]         product;
      rsp_type             outcome;
      case (item.operation)
         OP_CLEAR: begin
            for (int n = 0; n < 2*LEAVES-1; n++) tree_sums[n] = '0;
            weights_loaded = 0;
         end
         OP_LOAD: begin
            if (weights_loaded < LEAVES) begin
               node = LEAVES - 1 + weights_loaded;
               // negative weights count as zero
               tree_sums[node] = item.weight[WEIGHT_BITS-1] ? '0
                                 : SUM_BITS'(item.weight[WEIGHT_BITS-2:0]);
               rebuild_tree_path(node);
               weights_loaded++;
            end
         end
         OP_DRAW: begin
            if (tree_sums[0] == '0) begin
               outcome.chosen_index = '0;
               outcome.empty_res    = 1'b1;
            end else begin
               product = 64'(tree_sums[0]) * 64'(item.random_fraction);
               target  = SUM_BITS'(product >> FRACTION_BITS);
               node    = 0;
               while (node < LEAVES - 1) begin
                  if (target < tree_sums[2*node+1]) begin
                     node = 2*node + 1;
                  end else begin
                     target = target - tree_sums[2*node+1];
                     node   = 2*node + 2;
                  end
               end
               tree_sums[node] = '0;
               rebuild_tree_path(node);
               outcome.chosen_index = INDEX_BITS'(node - (LEAVES - 1));
               outcome.empty_res    = 1'b0;
            end
            expected_draws.push_back(outcome);
         end
         default: ;
      endcase
   endfunction

   function automatic req_type make_item(op_type code, logic [WEIGHT_BITS-1:0] weight,
                                         logic [FRACTION_BITS-1:0] fraction);
      req_type item;
      item.operation       = code;
      item.weight          = weight;
      item.random_fraction = fraction;
      return item;
   endfunction

   function automatic logic [WEIGHT_BITS-1:0] random_weight(weight_style_type style);
      logic [WEIGHT_BITS-1:0] edges [5];
      edges = '{16'h7FFF, 16'h0000, 16'h8000, 16'hFFFF, 16'h0001};
      case (style)
         WEIGHTS_ANY:      return WEIGHT_BITS'($urandom);
         WEIGHTS_POSITIVE: return WEIGHT_BITS'($urandom_range(0, 32767));
         WEIGHTS_TINY:     return WEIGHT_BITS'($urandom_range(0, 3));
         default:          return edges[$urandom_range(0, 4)];
      endcase
   endfunction

   function automatic logic [FRACTION_BITS-1:0] random_fraction();
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? '1 : '0;
      return FRACTION_BITS'($urandom);
   endfunction

   // Called at a clock edge; returns at the edge the item is accepted.
   task automatic send_item(req_type item);
      int gap;
      gap = 0;
      if (!quiet_phase && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      if (!(item.operation == op_type'(OP_UNUSED) ||
            (item.operation == OP_LOAD && weights_loaded >= LEAVES)))
         accepted_count++;
      predict_item(item);
   endtask

   // result channel stall: random bursts, one long hold-off on request
   initial begin
      int hold_count;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_count       = 0;
            rsp_stall <= 1'b1;
            while (hold_count < HOLD_OFF_CYCLES) begin
               @(posedge clock);
               hold_count++;
            end
            rsp_stall <= 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type expected;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_draws.size() == 0) begin
            $display("%0t: result expected none actual index %0d empty %0b", $time,
                     rsp_data.chosen_index, rsp_data.empty_res);
            error_count++;
         end else begin
            expected = expected_draws.pop_front();
            if (rsp_data.chosen_index !== expected.chosen_index) begin
               $display("%0t: chosen_index expected %0d actual %0d", $time,
                        expected.chosen_index, rsp_data.chosen_index);
               error_count++;
            end
            if (rsp_data.empty_res !== expected.empty_res) begin
               $display("%0t: empty_res expected %0b actual %0b", $time,
                        expected.empty_res, rsp_data.empty_res);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sum_tree_weighted_sampler verification failed");
         $finish;
      end
   end

   task automatic test_reset_state();
      send_item(make_item(OP_DRAW, 16'h1234, 16'h8000));
   endtask

   task automatic test_extreme_weights();
      send_item(make_item(OP_LOAD, 16'h7FFF, 16'h0000));
      send_item(make_item(OP_LOAD, 16'h8000, 16'hFFFF));
      send_item(make_item(OP_LOAD, 16'hFFFF, 16'h0000));
      send_item(make_item(OP_LOAD, 16'h0000, 16'hFFFF));
      send_item(make_item(OP_LOAD, 16'h0001, 16'h0000));
      send_item(make_item(OP_LOAD, 16'h7FFF, 16'hFFFF));
      // draw until the tree runs dry, then once more
      send_item(make_item(OP_DRAW, 16'h0000, 16'hFFFF));
      send_item(make_item(OP_DRAW, 16'hFFFF, 16'h0000));
      send_item(make_item(OP_DRAW, 16'h0000, 16'h0000));
      send_item(make_item(OP_DRAW, 16'h7FFF, 16'h8000));
   endtask

   task automatic test_unused_code();
      send_item(make_item(op_type'(OP_UNUSED), 16'h5A5A, 16'hA5A5));
      send_item(make_item(OP_DRAW, 16'h0000, 16'h0001));
   endtask

   task automatic test_clear();
      send_item(make_item(OP_LOAD, 16'd5, 16'h0000));
      send_item(make_item(OP_LOAD, 16'd7, 16'h0000));
      send_item(make_item(OP_CLEAR, 16'hFFFF, 16'hFFFF));
      send_item(make_item(OP_DRAW, 16'h0000, 16'h4000));
      send_item(make_item(OP_LOAD, 16'd9, 16'h0000));
      send_item(make_item(OP_DRAW, 16'h0000, 16'hC000));
   endtask

   task automatic test_receiver_hold_off();
      send_item(make_item(OP_CLEAR, 16'h0000, 16'h0000));
      repeat (8) send_item(make_item(OP_LOAD, random_weight(WEIGHTS_POSITIVE), 16'h0000));
      hold_off_request = 1'b1;
      repeat (24) send_item(make_item(OP_DRAW, WEIGHT_BITS'($urandom), random_fraction()));
   endtask

   task automatic run_sampling_round();
      int               loads;
      int               draws;
      weight_style_type style;
      if ($urandom_range(0, 9) == 0) begin
         // noise: any code, any content
         repeat ($urandom_range(4, 12))
            send_item(make_item(op_type'(OP_BITS'($urandom_range(0, 3))),
                                WEIGHT_BITS'($urandom), FRACTION_BITS'($urandom)));
         return;
      end
      if ($urandom_range(0, 4) != 0)
         send_item(make_item(OP_CLEAR, WEIGHT_BITS'($urandom), FRACTION_BITS'($urandom)));
      loads = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 16);
      style = weight_style_type'($urandom_range(0, 3));
      repeat (loads)
         send_item(make_item(OP_LOAD, random_weight(style), FRACTION_BITS'($urandom)));
      draws = $urandom_range(1, loads + 2);
      repeat (draws) begin
         if ($urandom_range(0, 11) == 0)
            send_item(make_item(OP_LOAD, random_weight(style), FRACTION_BITS'($urandom)));
         else
            send_item(make_item(OP_DRAW, WEIGHT_BITS'($urandom), random_fraction()));
      end
   endtask

   task automatic test_random_sampling();
      while (accepted_count < RANDOM_ITEMS) run_sampling_round();
   endtask

   task automatic test_back_to_back();
      quiet_phase = 1'b1;
      while (accepted_count < TOTAL_ITEMS) run_sampling_round();
   endtask

   initial begin
      error_count      = 0;
      accepted_count   = 0;
      cycle_count      = 0;
      quiet_phase      = 1'b0;
      hold_off_request = 1'b0;
      weights_loaded   = 0;
      for (int n = 0; n < 2*LEAVES-1; n++) tree_sums[n] = '0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_extreme_weights();
      test_unused_code();
      test_clear();
      test_receiver_hold_off();
      test_random_sampling();
      test_back_to_back();

      req_valid <= 1'b0;
      while (expected_draws.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_draws.size() == 0)
         $display("sum_tree_weighted_sampler verification clean");
      else
         $display("sum_tree_weighted_sampler verification failed");
      $finish;
   end

endmodule

[files.f]
src/sts_pkg.sv
src/sts_ram.sv
src/sts_alu.sv
src/sum_tree_weighted_sampler.sv
tb/sum_tree_weighted_sampler_tb.sv
